>>> rtl/core/gfsd_pkg.sv
`timescale 1ns / 1ps

package gfsd_pkg;

   // Frame markers
   localparam logic [7:0] HDR_BYTE   = 8'hFF;
   localparam logic [7:0] FTR_BYTE   = 8'hFE;
   localparam int         FTR_OFFSET = 18;

   // Byte offsets inside a frame
   localparam int BTN_OFFSET       = 2;
   localparam int LEFT_AXIS_OFFSET  = 6;
   localparam int RIGHT_AXIS_OFFSET = 10;

   // Button bits owned by each half of the controller
   localparam int                BTN_W          = 17;
   localparam logic [BTN_W-1:0] LEFT_BTN_MASK  = 17'h154F0;
   localparam logic [BTN_W-1:0] RIGHT_BTN_MASK = 17'h0AB0F;

   localparam int AXIS_W = 16;
   localparam int CAL_W  = 12;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = CAL_W;

   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_SELECT        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUTTONS_ACTIVE_LOW = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_FIRST_AXIS  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_SECOND_AXIS = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_AXIS_MIN     = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_AXIS_MAX     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_AXIS_MIN    = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_AXIS_MAX    = 4'd7;

   // Calibration reset values
   localparam logic [CAL_W-1:0] FIRST_AXIS_MIN_RST  = 12'd344;
   localparam logic [CAL_W-1:0] FIRST_AXIS_MAX_RST  = 12'd3655;
   localparam logic [CAL_W-1:0] SECOND_AXIS_MIN_RST = 12'd315;
   localparam logic [CAL_W-1:0] SECOND_AXIS_MAX_RST = 12'd3231;

   // Result payload: buttons, first axis, second axis, zero padded to bytes
   localparam int RSP_PAYLOAD_W = BTN_W + 2 * AXIS_W;
   localparam int RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;

   typedef struct packed {
      logic             side_select;
      logic             buttons_active_low;
      logic             invert_first_axis;
      logic             invert_second_axis;
      logic [CAL_W-1:0] first_axis_min;
      logic [CAL_W-1:0] first_axis_max;
      logic [CAL_W-1:0] second_axis_min;
      logic [CAL_W-1:0] second_axis_max;
   } cfg_type;

   // Mirror an axis about its calibration range, clamped at zero
   function automatic logic [AXIS_W-1:0] mirror_axis(
      input logic [AXIS_W-1:0] v,
      input logic [CAL_W-1:0]  lo,
      input logic [CAL_W-1:0]  hi,
      input logic              inv
   );
      logic [CAL_W:0]  sum;
      logic [AXIS_W-1:0] res;
      sum = {1'b0, lo} + {1'b0, hi};
      if (!inv) begin
         res = v;
      end else if (v >= AXIS_W'(sum)) begin
         res = '0;
      end else begin
         res = AXIS_W'(sum) - v;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/gamepad_frame_sync_decoder.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// req      | in  | req_tvalid / req_tready | tdata[7:0] rx_byte
// rsp      | out | rsp_tvalid / rsp_tready | tdata buttons, first_axis, second_axis;
//          |     |                         | tuser after_resync
// csr      | in  | csr_valid / csr_ready   | csr_index register, csr_data value
//
// One byte per cycle. Each accepted byte shifts into the window register; the
// frame check and decode sit between the window and the result register, so a
// frame is offered on rsp the cycle after its last byte. The only stall is the
// single result register: req_tready drops while a result waits and rsp_tready
// is low. Synchronous active-high reset empties the window, clears sync and
// rsp_tvalid and restores the config defaults; window contents are not reset.

module gamepad_frame_sync_decoder #(
   parameter int FRAME_BYTES = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   // slave side
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] rx_byte
   // master side
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [16:0] buttons, [32:17] first_axis, [48:33] second_axis, rest zero
   output logic [gfsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,   // [0] after_resync
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gfsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gfsd_pkg::CSR_DATA_W-1:0]     csr_data
);

   import gfsd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(FRAME_BYTES - 1);

   // Window: entry 0 is the oldest byte once the window is full
   logic [7:0]       win_ff [FRAME_BYTES];
   logic [7:0]       win_in [FRAME_BYTES];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             sync_ff, sync_in;
   cfg_type          cfg_ff, cfg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0]      btn_ff, btn_in;
   logic [AXIS_W-1:0]     ax1_ff, ax1_in;
   logic [AXIS_W-1:0]     ax2_ff, ax2_in;
   logic                  resync_ff, resync_in;

   logic req_fire;
   logic window_full;
   logic frame_hit;
   logic [BTN_W-1:0]  btn_raw;
   logic [AXIS_W-1:0] ax1_raw, ax2_raw;

   // Result register may be reloaded when it is empty or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Shift the new byte in; the check looks at the window as it will be
   always_comb begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[FRAME_BYTES-1] = req_tdata;
   end

   assign window_full = req_fire && (fill_ff == LAST_FILL);
   assign frame_hit   = window_full && (win_in[0] == HDR_BYTE)
                        && (win_in[FTR_OFFSET] == FTR_BYTE);

   // Field extraction
   always_comb begin
      btn_raw = {win_in[BTN_OFFSET+2][0], win_in[BTN_OFFSET+1], win_in[BTN_OFFSET]};
      if (cfg_ff.buttons_active_low) begin
         btn_raw = ~btn_raw;
      end
      if (cfg_ff.side_select) begin
         ax1_raw = {win_in[RIGHT_AXIS_OFFSET+1], win_in[RIGHT_AXIS_OFFSET]};
         ax2_raw = {win_in[RIGHT_AXIS_OFFSET+3], win_in[RIGHT_AXIS_OFFSET+2]};
      end else begin
         ax1_raw = {win_in[LEFT_AXIS_OFFSET+1], win_in[LEFT_AXIS_OFFSET]};
         ax2_raw = {win_in[LEFT_AXIS_OFFSET+3], win_in[LEFT_AXIS_OFFSET+2]};
      end
   end

   // Fill and sync tracking
   always_comb begin
      fill_in = fill_ff;
      sync_in = sync_ff;
      if (req_fire) begin
         if (frame_hit) begin
            fill_in = '0;
            sync_in = 1'b1;
         end else if (window_full) begin
            // bad header or footer: oldest byte falls out of the shift line
            fill_in = LAST_FILL;
            sync_in = 1'b0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      btn_in       = btn_ff;
      ax1_in       = ax1_ff;
      ax2_in       = ax2_ff;
      resync_in    = resync_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (frame_hit) begin
         rsp_valid_in = 1'b1;
         btn_in       = btn_raw & (cfg_ff.side_select ? RIGHT_BTN_MASK : LEFT_BTN_MASK);
         ax1_in       = mirror_axis(ax1_raw, cfg_ff.first_axis_min,
                                    cfg_ff.first_axis_max, cfg_ff.invert_first_axis);
         ax2_in       = mirror_axis(ax2_raw, cfg_ff.second_axis_min,
                                    cfg_ff.second_axis_max, cfg_ff.invert_second_axis);
         resync_in    = !sync_ff;
      end
   end

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SIDE_SELECT:        cfg_in.side_select        = csr_data[0];
            REG_BUTTONS_ACTIVE_LOW: cfg_in.buttons_active_low = csr_data[0];
            REG_INVERT_FIRST_AXIS:  cfg_in.invert_first_axis  = csr_data[0];
            REG_INVERT_SECOND_AXIS: cfg_in.invert_second_axis = csr_data[0];
            REG_FIRST_AXIS_MIN:     cfg_in.first_axis_min     = csr_data;
            REG_FIRST_AXIS_MAX:     cfg_in.first_axis_max     = csr_data;
            REG_SECOND_AXIS_MIN:    cfg_in.second_axis_min    = csr_data;
            REG_SECOND_AXIS_MAX:    cfg_in.second_axis_max    = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sync_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{side_select:        1'b0,
                           buttons_active_low: 1'b0,
                           invert_first_axis:  1'b0,
                           invert_second_axis: 1'b0,
                           first_axis_min:     FIRST_AXIS_MIN_RST,
                           first_axis_max:     FIRST_AXIS_MAX_RST,
                           second_axis_min:    SECOND_AXIS_MIN_RST,
                           second_axis_max:    SECOND_AXIS_MAX_RST};
      end else begin
         fill_ff      <= fill_in;
         sync_ff      <= sync_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_ff <= win_in;
      end
      btn_ff    <= btn_in;
      ax1_ff    <= ax1_in;
      ax2_ff    <= ax2_in;
      resync_ff <= resync_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_PAYLOAD_W)'(0), ax2_ff, ax1_ff, btn_ff};
   assign rsp_tuser  = resync_ff;

   // Fill count stays below a full window between transactions
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_FILL)
      else $error("window fill count out of range");

   // A decoded frame empties the window and marks the stream in sync
   a_hit_clears: assert property (@(posedge clock) disable iff (reset)
      frame_hit |=> (fill_ff == '0) && sync_ff && rsp_valid_ff)
      else $error("frame match did not restart window");

   // A partial window only grows by one
   a_partial_grow: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !window_full) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("partial window fill did not advance");

   // A failed check drops exactly one byte and loses sync
   a_miss_drop: assert property (@(posedge clock) disable iff (reset)
      (window_full && !frame_hit) |=> (fill_ff == LAST_FILL) && !sync_ff)
      else $error("header or footer mismatch not handled");

endmodule
